@@ sv/bglt_pkg.sv @@
// Package for the battery gauge level tracker: payload structs, fixed sizes,
// register indexes and the controller state type. No dependencies.
`default_nettype none

package bglt_pkg;

  localparam int LEVEL_MAX   = 5;
  localparam int SAMPLE_BITS = 10;
  localparam int LEVEL_BITS  = 3;
  localparam int TIME_BITS   = 32;
  localparam int IVL_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Dividend is the offset above the floor times the number of levels.
  localparam int NUM_BITS = SAMPLE_BITS + $clog2(LEVEL_MAX + 2);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_CEILING = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_INTERVAL = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] FLOOR_RESET    = SAMPLE_BITS'(527);
  localparam logic [SAMPLE_BITS-1:0] CEILING_RESET  = SAMPLE_BITS'(620);
  localparam logic [IVL_BITS-1:0]    INTERVAL_RESET = IVL_BITS'(500);

  typedef struct packed {
    logic [TIME_BITS-1:0]   now_ms;
    logic                   charging;
    logic [SAMPLE_BITS-1:0] battery_sample;
  } in_item_t;

  typedef struct packed {
    logic                  changed;
    logic [LEVEL_BITS-1:0] gauge_level;
    logic                  visible;
    logic                  is_depleted;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ sv/battery_gauge_level_tracker.sv @@
// Battery gauge level tracker: maps a sample to a gauge level with a bit-serial
// restoring divider and applies the interval, blink and charging rules.
// Depends on bglt_pkg.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall  in_data (now_ms, charging, battery_sample)
//   out       from block out_valid / out_stall out_data (changed, gauge_level, visible,
//                                               is_depleted)
//   cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A charging update, or one with the ceiling not above the floor, goes from
// acceptance straight to ST_DONE; any other first passes through ST_DIV, where
// the divider retires one quotient bit per cycle, before reaching ST_DONE.
// ST_DONE writes the result register once the output register is free, and the
// next update is accepted in the cycle after the result is written.
// One update is in work at a time; a result waiting in the output register does
// not block acceptance, only the write of the following result.
// Reset (rst, synchronous) restores register defaults, the gauge state and
// empties the output register. Configuration writes are always taken.
`default_nettype none

module battery_gauge_level_tracker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  bglt_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output bglt_pkg::out_item_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [bglt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [bglt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import bglt_pkg::*;

  localparam int DIV_BITS = SAMPLE_BITS;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] sample_floor;
  logic [SAMPLE_BITS-1:0] sample_ceiling;
  logic [IVL_BITS-1:0]    frame_interval_ms;

  // Gauge state.
  logic [TIME_BITS-1:0]  last_change_ms;
  logic [LEVEL_BITS-1:0] current_level;
  logic                  draw_phase;
  logic                  depleted_flag;

  // Captured update.
  logic [TIME_BITS-1:0]  now_ms;
  logic                  chg;
  logic                  below_floor;
  logic                  no_span;
  logic [DIV_BITS-1:0]   divisor;
  logic [NUM_BITS-1:0]   num;        // dividend, becomes the quotient
  logic [DIV_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]   cnt;

  state_t state, state_next;
  logic   accept_in;
  logic   div_step;
  logic   finish;

  assign cfg_ready = 1'b1;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_floor      <= FLOOR_RESET;
      sample_ceiling    <= CEILING_RESET;
      frame_interval_ms <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_FLOOR:   sample_floor      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_SAMPLE_CEILING: sample_ceiling    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_FRAME_INTERVAL: frame_interval_ms <= cfg_data[IVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (in_data.charging || (sample_ceiling <= sample_floor)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt == CNT_BITS'(NUM_BITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    div_step = 1'b0;
    finish   = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_DIV:  div_step = 1'b1;
      ST_DONE: finish   = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Capture and serial division.
  logic [SAMPLE_BITS-1:0] above;
  logic [NUM_BITS-1:0]    above_ext;
  logic [DIV_BITS:0]      rem_shift;
  logic                   rem_ge;

  always_comb begin
    above     = (in_data.battery_sample < sample_floor) ? '0
                : in_data.battery_sample - sample_floor;
    above_ext = NUM_BITS'(above);
    rem_shift = {rem, num[NUM_BITS-1]};
    rem_ge    = rem_shift >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      now_ms      <= in_data.now_ms;
      chg         <= in_data.charging;
      below_floor <= in_data.battery_sample < sample_floor;
      no_span     <= sample_ceiling <= sample_floor;
      divisor     <= sample_ceiling - sample_floor;
      num         <= NUM_BITS'(above_ext * NUM_BITS'(LEVEL_MAX + 1));
      rem         <= '0;
      cnt         <= '0;
    end else if (div_step) begin
      rem <= rem_ge ? DIV_BITS'(rem_shift - {1'b0, divisor}) : rem_shift[DIV_BITS-1:0];
      num <= {num[NUM_BITS-2:0], rem_ge};
      cnt <= cnt + CNT_BITS'(1);
    end
  end

  // Update rules, evaluated once the quotient is ready.
  logic [TIME_BITS-1:0]  elapsed;
  logic                  passed;
  logic [LEVEL_BITS-1:0] lvl;
  logic                  adopt;
  logic                  blink;
  logic [TIME_BITS-1:0]  last_next;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  draw_next;
  logic                  dep_next;
  logic                  changed_next;

  always_comb begin
    elapsed = now_ms - last_change_ms;
    passed  = elapsed > TIME_BITS'(frame_interval_ms);
    if (no_span || (num > NUM_BITS'(LEVEL_MAX))) begin
      lvl = LEVEL_BITS'(LEVEL_MAX);
    end else begin
      lvl = num[LEVEL_BITS-1:0];
    end
    last_next    = last_change_ms;
    level_next   = current_level;
    draw_next    = draw_phase;
    dep_next     = depleted_flag;
    changed_next = 1'b0;
    adopt        = 1'b0;
    blink        = 1'b0;
    if (chg) begin
      draw_next = 1'b1;
      dep_next  = 1'b0;
      if (passed) begin
        level_next   = (current_level == LEVEL_BITS'(LEVEL_MAX)) ? '0
                       : current_level + LEVEL_BITS'(1);
        last_next    = now_ms;
        changed_next = 1'b1;
      end
    end else begin
      dep_next = below_floor;
      adopt    = (lvl != current_level) && passed;
      if (adopt) begin
        level_next   = lvl;
        last_next    = now_ms;
        changed_next = 1'b1;
      end
      if (level_next == '0) begin
        // A level adopted on this update resets the elapsed time to zero.
        blink = passed && !adopt;
        if (blink) begin
          draw_next    = !draw_phase;
          last_next    = now_ms;
          changed_next = 1'b1;
        end
      end else begin
        draw_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_change_ms <= '0;
      current_level  <= '0;
      draw_phase     <= 1'b1;
      depleted_flag  <= 1'b0;
    end else if (finish) begin
      last_change_ms <= last_next;
      current_level  <= level_next;
      draw_phase     <= draw_next;
      depleted_flag  <= dep_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.changed     <= changed_next;
      out_data.gauge_level <= level_next;
      out_data.visible     <= draw_next;
      out_data.is_depleted <= dep_next;
    end
  end

endmodule

`default_nettype wire

@@ bench/battery_gauge_level_tracker_tb.sv @@
// Testbench for the battery gauge level tracker: a gauge predictor, directed
// tests and randomized traffic under changing configuration and idle patterns.
// Depends on bglt_pkg and battery_gauge_level_tracker.
`default_nettype none

module battery_gauge_level_tracker_tb;
  import bglt_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = 2'd3;
  localparam int SETTLE_CYCLES = NUM_BITS + 8;
  localparam int RANDOM_BLOCKS = 4;
  localparam int BLOCK_ITEMS   = 119;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  battery_gauge_level_tracker DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predicted gauge state and register copies.
  logic [SAMPLE_BITS-1:0] floor_r   = FLOOR_RESET;
  logic [SAMPLE_BITS-1:0] ceiling_r = CEILING_RESET;
  logic [IVL_BITS-1:0]    ivl_r     = INTERVAL_RESET;
  logic [TIME_BITS-1:0]   mark_ms   = '0;
  logic [LEVEL_BITS-1:0]  lvl_now   = '0;
  logic                   draw_on   = 1'b1;
  logic                   low_flag  = 1'b0;

  out_item_t pending_readings[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int updates_sent = 0;
  int readings_checked = 0;
  int readings_changed = 0;
  int reg_writes = 0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  function automatic bit interval_elapsed(logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] gap;
    gap = now - mark_ms;
    return gap > {{(TIME_BITS-IVL_BITS){1'b0}}, ivl_r};
  endfunction

  // Maps a sample onto the gauge scale and refreshes the depleted flag.
  function automatic logic [LEVEL_BITS-1:0] sample_level(logic [SAMPLE_BITS-1:0] s);
    int unsigned above;
    int unsigned span;
    int unsigned q;
    if (s < floor_r) begin
      low_flag = 1'b1;
      above = 0;
    end else begin
      low_flag = 1'b0;
      above = int'(s) - int'(floor_r);
    end
    if (ceiling_r <= floor_r) return LEVEL_BITS'(LEVEL_MAX);
    span = int'(ceiling_r) - int'(floor_r);
    q = (above * (LEVEL_MAX + 1)) / span;
    if (q > LEVEL_MAX) q = LEVEL_MAX;
    return LEVEL_BITS'(q);
  endfunction

  function automatic out_item_t advance_gauge(in_item_t it);
    out_item_t r;
    logic [LEVEL_BITS-1:0] target;
    logic moved;
    moved = 1'b0;
    if (it.charging) begin
      draw_on = 1'b1;
      low_flag = 1'b0;
      if (interval_elapsed(it.now_ms)) begin
        lvl_now = (lvl_now == LEVEL_MAX) ? '0 : LEVEL_BITS'(lvl_now + 1);
        mark_ms = it.now_ms;
        moved = 1'b1;
      end
    end else begin
      target = sample_level(it.battery_sample);
      if (target != lvl_now && interval_elapsed(it.now_ms)) begin
        mark_ms = it.now_ms;
        lvl_now = target;
        moved = 1'b1;
      end
      // An empty gauge blinks; any other level is drawn steadily.
      if (lvl_now == 0) begin
        if (interval_elapsed(it.now_ms)) begin
          draw_on = ~draw_on;
          mark_ms = it.now_ms;
          moved = 1'b1;
        end
      end else begin
        draw_on = 1'b1;
      end
    end
    r.changed = moved;
    r.gauge_level = lvl_now;
    r.visible = draw_on;
    r.is_depleted = low_flag;
    return r;
  endfunction

  task automatic send_reading(input logic [TIME_BITS-1:0] t, input logic chg,
                              input logic [SAMPLE_BITS-1:0] s);
    in_item_t it;
    it.now_ms = t;
    it.charging = chg;
    it.battery_sample = s;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(advance_gauge(it));
    updates_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLE_FLOOR:   floor_r = d[SAMPLE_BITS-1:0];
      CFG_SAMPLE_CEILING: ceiling_r = d[SAMPLE_BITS-1:0];
      CFG_FRAME_INTERVAL: ivl_r = d[IVL_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding reading drain so that registers can be rewritten.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("gauge reading with no update outstanding: %p", out_data);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (want.changed) readings_changed++;
        if (out_data.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, out_data.changed);
          fail_count++;
        end
        if (out_data.gauge_level !== want.gauge_level) begin
          $error("gauge_level: expected %0d, got %0d", want.gauge_level,
                 out_data.gauge_level);
          fail_count++;
        end
        if (out_data.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, out_data.visible);
          fail_count++;
        end
        if (out_data.is_depleted !== want.is_depleted) begin
          $error("is_depleted: expected %0d, got %0d", want.is_depleted,
                 out_data.is_depleted);
          fail_count++;
        end
      end
    end
  end

  // Reset values: depletion, blink on an empty gauge, adoption only after the
  // interval, and no blink on the update that adopts a level.
  task automatic test_reset_defaults();
    send_reading(32'd0, 1'b0, 10'd0);
    send_reading(32'd501, 1'b0, 10'd0);
    send_reading(32'd1001, 1'b0, 10'd1023);
    send_reading(32'd1002, 1'b0, 10'd1023);
    send_reading(32'd1003, 1'b0, 10'd620);
    send_reading(32'd1600, 1'b0, 10'd527);
    clock_ms = 32'd1600;
  endtask

  // Charging walks the level through its full cycle, wrapping back to empty.
  task automatic test_charging_cycle();
    send_reading(clock_ms + 1, 1'b1, 10'h3FF);
    for (int i = 0; i < 6; i++) begin
      clock_ms += 501;
      send_reading(clock_ms, 1'b1, 10'($urandom));
    end
  endtask

  task automatic test_time_wrap();
    send_reading(32'hFFFF_FF00, 1'b0, 10'd1023);
    send_reading(32'h0000_0010, 1'b0, 10'd527);
    send_reading(32'h0000_0300, 1'b0, 10'd527);
    clock_ms = 32'h0000_0300;
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(CFG_SAMPLE_FLOOR, 16'h0000);
    write_reg(CFG_SAMPLE_CEILING, 16'hFFFF);
    write_reg(CFG_FRAME_INTERVAL, 16'h0000);
    send_reading(clock_ms + 1, 1'b0, 10'd1023);
    send_reading(clock_ms + 2, 1'b0, 10'd0);
    send_reading(clock_ms + 3, 1'b0, 10'd170);
    send_reading(clock_ms + 4, 1'b0, 10'd171);
    clock_ms += 4;
    wait_idle();
    // Ceiling below, then equal to, the floor: the level saturates.
    write_reg(CFG_SAMPLE_FLOOR, 16'hFFFF);
    write_reg(CFG_SAMPLE_CEILING, 16'h0000);
    send_reading(clock_ms + 1, 1'b0, 10'd0);
    send_reading(clock_ms + 2, 1'b0, 10'd1023);
    clock_ms += 2;
    wait_idle();
    write_reg(CFG_SAMPLE_CEILING, 16'hFC00 | 16'd1023);
    write_reg(CFG_FRAME_INTERVAL, 16'hFFFF);
    send_reading(clock_ms + 1, 1'b0, 10'd1023);
    wait_idle();
    write_reg(CFG_SAMPLE_FLOOR, 16'h0000);
    send_reading(clock_ms + 32'd65535, 1'b0, 10'd0);
    send_reading(clock_ms + 32'd65536, 1'b0, 10'd0);
    clock_ms += 32'd65536;
    send_reading(clock_ms + 32'd65536, 1'b0, 10'd0);
    clock_ms += 32'd65536;
  endtask

  // A write to the unused index must leave every register untouched.
  task automatic test_unused_register();
    wait_idle();
    write_reg(CFG_NO_REG, 16'h0001);
    send_reading(clock_ms + 32'd70000, 1'b0, 10'd0);
    clock_ms += 32'd70000;
  endtask

  task automatic random_setup();
    logic [SAMPLE_BITS-1:0] f;
    logic [SAMPLE_BITS-1:0] c;
    logic [IVL_BITS-1:0] iv;
    f = SAMPLE_BITS'($urandom_range(1023));
    if ($urandom_range(9) == 0) c = SAMPLE_BITS'($urandom_range(1023));
    else c = SAMPLE_BITS'(f + $urandom_range(1, 300));
    case ($urandom_range(3))
      0: iv = '0;
      1: iv = IVL_BITS'($urandom_range(1, 40));
      2: iv = IVL_BITS'($urandom_range(100, 2000));
      default: iv = IVL_BITS'($urandom);
    endcase
    wait_idle();
    write_reg(CFG_SAMPLE_FLOOR, {6'($urandom), f});
    write_reg(CFG_SAMPLE_CEILING, {6'($urandom), c});
    write_reg(CFG_FRAME_INTERVAL, iv);
  endtask

  // Time mostly advances around the interval so that level changes and blinks
  // occur often; rare jumps cover the whole time range and wrapping.
  task automatic run_random_block(input int n);
    logic [TIME_BITS-1:0] step;
    logic chg;
    logic [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        clock_ms = $urandom;
      end else begin
        case ($urandom_range(3))
          0: step = $urandom_range(3);
          1: step = {16'd0, ivl_r} + $urandom_range(2) - 1;
          default: step = $urandom_range(0, 2 * int'(ivl_r) + 4);
        endcase
        clock_ms += step;
      end
      chg = ($urandom_range(99) < 25);
      case ($urandom_range(9))
        0, 1: s = SAMPLE_BITS'($urandom);
        2: s = (floor_r == 0) ? '0 : SAMPLE_BITS'($urandom_range(0, floor_r - 1));
        default: s = SAMPLE_BITS'($urandom_range(floor_r, ceiling_r));
      endcase
      send_reading(clock_ms, chg, s);
    end
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      random_setup();
      run_random_block(BLOCK_ITEMS);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    test_reset_defaults();
    test_charging_cycle();
    test_time_wrap();
    test_config_extremes();
    test_unused_register();
    test_random_traffic(12, 76);
    test_random_traffic(76, 12);
    test_random_traffic(0, 0);
    wait_idle();
    $display("Run covered %0d gauge updates and %0d register writes across three idle mixes;",
             updates_sent, reg_writes);
    $display("%0d readings were compared, %0d of them reporting a change.",
             readings_checked, readings_changed);
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/bglt_pkg.sv
sv/battery_gauge_level_tracker.sv
bench/battery_gauge_level_tracker_tb.sv
